// ===== rtl/core/nearest_landmark_association_core_macros.svh =====
// Assertion macros shared by the nearest landmark association RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NEAREST_LANDMARK_ASSOCIATION_CORE_MACROS_SVH
`define NEAREST_LANDMARK_ASSOCIATION_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define NLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define NLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/nla_pkg.sv =====
// Package for the nearest landmark association core: payload words,
// command codes and status codes. Depends on nothing.
package nla_pkg;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [19:0] coord_x;
        logic signed [19:0] coord_y;
        logic [15:0]       landmark_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] nearest_id;
        logic [41:0] nearest_sq_distance;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_IGNORE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic signed [19:0] coord_x;
        logic signed [19:0] coord_y;
        logic [15:0]       landmark_id;
    } t_cmd;

endpackage

// ===== rtl/core/nla_front.sv =====
// Front end: accepts input words, decodes the mode into a command and
// holds it until the command queue takes it. Depends on nla_pkg.
module nla_front
    import nla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_op  n_op;

    always_comb begin
        case (i_in_item.mode)
            MODE_CLEAR:  n_op = OP_CLEAR;
            MODE_APPEND: n_op = OP_APPEND;
            MODE_QUERY:  n_op = OP_QUERY;
            default:     n_op = OP_IGNORE;
        endcase
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd.op          <= n_op;
            r_cmd.coord_x     <= i_in_item.coord_x;
            r_cmd.coord_y     <= i_in_item.coord_y;
            r_cmd.landmark_id <= i_in_item.landmark_id;
        end
    end

endmodule

// ===== rtl/core/nla_cmd_queue.sv =====
// Short command queue between the front end and the back end, so that
// each side can stall on its own. Depends on nla_pkg.
module nla_cmd_queue
    import nla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill;
    logic          n_push;
    logic          n_pop;

    assign o_push_ready = (r_fill != FW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign n_push       = i_push_valid && o_push_ready;
    assign n_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (n_pop && !n_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/core/nla_back.sv =====
// Back end: owns the landmark table and the entry count, carries out
// clear, append and query commands and holds the result word.
// Depends on nla_pkg and the assertion macro header.
`include "nearest_landmark_association_core_macros.svh"

module nla_back
    import nla_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [15:0]       id;
    } t_entry;

    typedef enum logic {
        S_IDLE,
        S_QUERY
    } t_state;

    t_entry r_table [TABLE_DEPTH];

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_issue;
    logic               r_v1, r_v2, r_v3;
    logic               r_last1, r_last2, r_last3;
    logic               r_have_best;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic signed [19:0] r_qx, r_qy;
    t_entry             r_rd_data;
    logic [19:0]        r_adx, r_ady;
    logic [15:0]        r_id2, r_id3;
    logic [39:0]        r_sqx, r_sqy;
    logic [40:0]        r_best;
    logic [15:0]        r_best_id;

    logic               n_pop;
    logic               n_full;
    logic               n_write;
    logic signed [20:0] n_dx, n_dy;
    logic [40:0]        n_sum;
    logic               n_better;
    logic [1:0]         n_status;

    assign o_cmd_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign n_pop       = i_cmd_valid && o_cmd_ready;
    assign n_full      = (r_count >= CW'(TABLE_DEPTH));
    assign n_write     = n_pop && (i_cmd.op == OP_APPEND) && !n_full;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign n_dx     = 21'(r_qx) - 21'(r_rd_data.x);
    assign n_dy     = 21'(r_qy) - 21'(r_rd_data.y);
    assign n_sum    = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign n_better = !r_have_best || (n_sum < r_best);

    always_comb begin
        case (i_cmd.op)
            OP_APPEND: n_status = n_full ? STATUS_FULL : STATUS_OK;
            OP_QUERY:  n_status = (r_count == '0) ? STATUS_EMPTY : STATUS_OK;
            default:   n_status = STATUS_OK;
        endcase
    end

    // Table storage: one write port for appends, one registered read port for the walk.
    always_ff @(posedge i_clk) begin
        if (n_write) begin
            r_table[r_count[AW-1:0]] <= '{x: i_cmd.coord_x, y: i_cmd.coord_y,
                                          id: i_cmd.landmark_id};
        end
        r_rd_data <= r_table[r_idx[AW-1:0]];
    end

    // Distance pipeline: absolute differences, then squares.
    always_ff @(posedge i_clk) begin
        r_adx <= n_dx[20] ? 20'(-n_dx) : n_dx[19:0];
        r_ady <= n_dy[20] ? 20'(-n_dy) : n_dy[19:0];
        r_id2 <= r_rd_data.id;
        r_sqx <= r_adx * r_adx;
        r_sqy <= r_ady * r_ady;
        r_id3 <= r_id2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_last1     <= 1'b0;
            r_last2     <= 1'b0;
            r_last3     <= 1'b0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1    <= r_issue;
            r_last1 <= r_issue && (CW'(r_idx + 1'b1) == r_count);
            r_v2    <= r_v1;
            r_last2 <= r_v1 && r_last1;
            r_v3    <= r_v2;
            r_last3 <= r_v2 && r_last2;

            case (r_state)
                S_IDLE: begin
                    if (n_pop) begin
                        r_out_item  <= '{nearest_id: '0, nearest_sq_distance: '0,
                                         status: n_status};
                        // A query on a filled table posts its word only when the walk ends.
                        r_out_valid <= !((i_cmd.op == OP_QUERY) && (r_count != '0));
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_APPEND: begin
                                if (!n_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                if (r_count != '0) begin
                                    r_state     <= S_QUERY;
                                    r_issue     <= 1'b1;
                                    r_idx       <= '0;
                                    r_have_best <= 1'b0;
                                    r_qx        <= i_cmd.coord_x;
                                    r_qy        <= i_cmd.coord_y;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_QUERY: begin
                    if (r_issue) begin
                        r_idx <= r_idx + 1'b1;
                        if (CW'(r_idx + 1'b1) == r_count) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_v3) begin
                        r_have_best <= 1'b1;
                        if (n_better) begin
                            r_best    <= n_sum;
                            r_best_id <= r_id3;
                        end
                        if (r_last3) begin
                            r_out_valid <= 1'b1;
                            r_out_item  <= '{
                                nearest_id:          n_better ? r_id3 : r_best_id,
                                nearest_sq_distance: {1'b0, n_better ? n_sum : r_best},
                                status:              STATUS_OK
                            };
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `NLA_ASSERT(a_no_pop_busy, i_clk, i_rst_n, (r_state == S_QUERY) |-> !n_pop, "pop in query")
    `NLA_ASSERT(a_count_bounded, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH), "count overflow")
    `NLA_ASSERT(a_slot_free, i_clk, i_rst_n, (r_v3 && r_last3) |-> !r_out_valid, "result lost")
    `NLA_ASSERT(a_idle_quiet, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_v3, "stray walk")
    `NLA_ASSERT(a_query_done, i_clk, i_rst_n, (r_v3 && r_last3) |=> r_out_valid, "no result")

endmodule

// ===== rtl/core/nearest_landmark_association_core.sv =====
// Nearest landmark association core: top level joining the front end,
// the command queue and the back end. Depends on nla_pkg and the three
// submodules.

// Each input word clears the landmark table, appends a landmark, or queries
// with an observation point; every word yields exactly one result word. A
// word passes the front register and the two-entry command queue before the
// back end takes it. A query walks the table in the back end: the table
// has a single registered read port and is walked one entry per cycle,
// followed by the difference, square and compare stages. The back end
// starts the next word once the previous result has left or is leaving
// the output register. No clearing pass is run after reset; the table is
// used only below the entry count.
module nearest_landmark_association_core
    import nla_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic f_valid, f_ready;
    t_cmd f_cmd;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    nla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    nla_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    nla_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sim/landmark_match_pkg.sv =====
// Scoreboard class for the nearest landmark association testbench: it keeps its own
// copy of the landmark table, predicts each result word and checks the words that leave.
// Depends on nla_pkg.
package landmark_match_pkg;
    import nla_pkg::*;

    localparam int unsigned LANDMARK_SLOTS = 64;
    localparam int unsigned REPORT_LIMIT   = 10;

    class landmark_match_board;
        typedef struct packed {
            logic signed [19:0] x;
            logic signed [19:0] y;
            logic [15:0]        id;
        } t_landmark;

        t_landmark   stored[LANDMARK_SLOTS];
        int unsigned stored_count;
        t_out_item   pending_matches[$];
        int unsigned mismatches;

        function new();
            stored_count = 0;
            mismatches   = 0;
        endfunction

        // The largest difference is 2^20 - 1, so the sum of squares fits in 42 bits.
        function longint squared_range(logic signed [19:0] ax, logic signed [19:0] ay,
                                       logic signed [19:0] bx, logic signed [19:0] by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return dx * dx + dy * dy;
        endfunction

        function int unsigned pending_count();
            return pending_matches.size();
        endfunction

        function void note_input_word(t_in_item w);
            t_out_item   e;
            longint      best;
            longint      d;
            int unsigned j;
            e = '0;
            case (w.mode)
                MODE_CLEAR: begin
                    stored_count = 0;
                end
                MODE_APPEND: begin
                    if (stored_count >= LANDMARK_SLOTS) begin
                        e.status = STATUS_FULL;
                    end else begin
                        stored[stored_count] = '{w.coord_x, w.coord_y, w.landmark_id};
                        stored_count++;
                    end
                end
                MODE_QUERY: begin
                    if (stored_count == 0) begin
                        e.status = STATUS_EMPTY;
                    end else begin
                        best = squared_range(w.coord_x, w.coord_y, stored[0].x, stored[0].y);
                        e.nearest_id = stored[0].id;
                        // Only a strictly smaller distance wins, so the earliest entry
                        // keeps a tie.
                        for (j = 1; j < stored_count; j++) begin
                            d = squared_range(w.coord_x, w.coord_y, stored[j].x, stored[j].y);
                            if (d < best) begin
                                best = d;
                                e.nearest_id = stored[j].id;
                            end
                        end
                        e.nearest_sq_distance = best[41:0];
                    end
                end
                default: begin
                    // The unused mode leaves the table alone and gives an all-zero word.
                end
            endcase
            pending_matches.insert(pending_matches.size(), e);
        endfunction

        function void check_result_word(t_out_item got);
            t_out_item e;
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: id %0h dist %0h status %0d",
                             got.nearest_id, got.nearest_sq_distance, got.status);
            end else begin
                e = pending_matches.pop_front();
                if (got.nearest_id !== e.nearest_id ||
                    got.nearest_sq_distance !== e.nearest_sq_distance ||
                    got.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected id %0h dist %0h status %0d,",
                                 e.nearest_id, e.nearest_sq_distance, e.status,
                                 " got id %0h dist %0h status %0d",
                                 got.nearest_id, got.nearest_sq_distance, got.status);
                end
            end
        endfunction
    endclass

endpackage

// ===== sim/testbench.sv =====
// Top-level testbench for nearest_landmark_association_core: drives clear, append and
// query words with random idling and back-pressure and checks every result word.
// Depends on nla_pkg, landmark_match_pkg and the core RTL.
module testbench;
    import nla_pkg::*;
    import landmark_match_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned WORD_TARGET = 600;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    landmark_match_board board = new();

    int unsigned tx_idle_pct = 25;
    int unsigned rx_idle_pct = 75;
    int unsigned sent_count = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned cycle_count = 0;

    nearest_landmark_association_core #(
        .TABLE_DEPTH(LANDMARK_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the core fills up.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            board.check_result_word(o_out_item);
        end
    end

    function automatic t_in_item make_word(logic [1:0] mode, logic signed [19:0] x,
                                           logic signed [19:0] y, logic [15:0] id);
        t_in_item w;
        w.mode        = mode;
        w.coord_x     = x;
        w.coord_y     = y;
        w.landmark_id = id;
        return w;
    endfunction

    function automatic logic signed [19:0] pick_coord();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(1) ? 524287 : -524288;
            1: v = int'($urandom_range(4000)) - 2000;
            default: v = $urandom;
        endcase
        return v[19:0];
    endfunction

    task automatic send_word(input t_in_item w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_input_word(w);
        if (w.mode != MODE_UNUSED) sent_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_count() != 0) @(posedge i_clk);
    endtask

    task automatic send_query(input bit near);
        int unsigned      idx;
        int               off_x;
        int               off_y;
        logic signed [19:0] qx;
        logic signed [19:0] qy;
        if (near && board.stored_count > 0) begin
            idx   = $urandom_range(board.stored_count - 1);
            off_x = int'($urandom_range(128)) - 64;
            off_y = int'($urandom_range(128)) - 64;
            qx    = board.stored[idx].x + off_x[19:0];
            qy    = board.stored[idx].y + off_y[19:0];
        end else begin
            qx = pick_coord();
            qy = pick_coord();
        end
        send_word(make_word(MODE_QUERY, qx, qy, 16'($urandom)));
    endtask

    // A well-formed run: optional clear, a batch of landmarks (sometimes enough to
    // overflow the table, sometimes with repeated positions for ties), then queries.
    task automatic send_landmark_run();
        int unsigned        n;
        int unsigned        q;
        int unsigned        k;
        logic signed [19:0] x;
        logic signed [19:0] y;
        if ($urandom_range(1)) send_word(make_word(MODE_CLEAR, pick_coord(), pick_coord(),
                                                   16'($urandom)));
        n = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 12);
        x = pick_coord();
        y = pick_coord();
        for (k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(99) >= 15) begin
                x = pick_coord();
                y = pick_coord();
            end
            send_word(make_word(MODE_APPEND, x, y, 16'($urandom)));
        end
        q = $urandom_range(1, 6);
        for (k = 0; k < q; k++) send_query($urandom_range(99) < 60);
    endtask

    initial begin
        int unsigned k;
        int unsigned pick;
        int unsigned phase;
        phase = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: empty table, unused mode, coordinate extremes and ties.
        send_word(make_word(MODE_QUERY, 20'sh7FFFF, 20'sh80000, 16'hFFFF));
        send_word(make_word(MODE_UNUSED, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF));
        send_word(make_word(MODE_CLEAR, 20'sh80000, 20'sh80000, 16'hFFFF));
        send_word(make_word(MODE_APPEND, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF));
        send_word(make_word(MODE_APPEND, 20'sh80000, 20'sh80000, 16'h0000));
        send_word(make_word(MODE_QUERY, 20'sh80000, 20'sh80000, 16'h0000));
        send_word(make_word(MODE_QUERY, 20'sh7FFFF, 20'sh7FFFF, 16'h0000));
        send_word(make_word(MODE_QUERY, 20'sh7FFFF, 20'sh80000, 16'h0000));
        send_word(make_word(MODE_QUERY, 20'sh80000, 20'sh7FFFF, 16'hFFFF));
        send_word(make_word(MODE_APPEND, 20'sh00000, 20'sh00000, 16'h0001));
        send_word(make_word(MODE_APPEND, 20'sh00000, 20'sh00000, 16'h0002));
        send_word(make_word(MODE_QUERY, 20'sh00000, 20'sh00000, 16'h0000));
        send_word(make_word(MODE_APPEND, 20'sh00100, 20'sh00000, 16'h0003));
        send_word(make_word(MODE_QUERY, 20'sh00080, 20'sh00000, 16'h0000));
        send_word(make_word(MODE_UNUSED, 20'sh00000, 20'sh00000, 16'h0000));
        send_word(make_word(MODE_QUERY, 20'shFFF80, 20'sh00001, 16'hAAAA));
        send_word(make_word(MODE_CLEAR, 20'sh00000, 20'sh00000, 16'h0000));
        send_word(make_word(MODE_QUERY, 20'sh00000, 20'sh00000, 16'h0000));
        send_word(make_word(MODE_APPEND, 20'sh55555, 20'shAAAAA, 16'h5555));
        send_word(make_word(MODE_QUERY, 20'shAAAAA, 20'sh55555, 16'h5555));

        // Fill the table past its depth so that appends are dropped, then query it.
        send_word(make_word(MODE_CLEAR, 20'sh00000, 20'sh00000, 16'h0000));
        for (k = 0; k < LANDMARK_SLOTS + 2; k++)
            send_word(make_word(MODE_APPEND, pick_coord(), pick_coord(), 16'($urandom)));
        send_query(1'b1);
        send_query(1'b0);

        while (sent_count < WORD_TARGET) begin
            if (phase == 0 && sent_count >= WORD_TARGET / 3) begin
                drain_results();
                phase       = 1;
                tx_idle_pct = 75;
                rx_idle_pct = 25;
            end else if (phase == 1 && sent_count >= 2 * WORD_TARGET / 3) begin
                drain_results();
                phase       = 2;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 8)
                send_word(make_word(MODE_UNUSED, pick_coord(), pick_coord(), 16'($urandom)));
            else if (pick < 14)
                send_word(make_word(MODE_CLEAR, pick_coord(), pick_coord(), 16'($urandom)));
            else if (pick < 22)
                send_query(1'b0);
            else
                send_landmark_run();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/nla_pkg.sv
rtl/core/nla_front.sv
rtl/core/nla_cmd_queue.sv
rtl/core/nla_back.sv
rtl/core/nearest_landmark_association_core.sv
sim/landmark_match_pkg.sv
sim/testbench.sv
